// ===== design/fce_pkg.sv =====
// Shared constants and mixing functions for the feedback comb echo unit.
`default_nettype none

package fce_pkg;

    localparam int MAX_DELAY_DEF = 4096;
    localparam int SAMPLE_W      = 16;
    localparam int DELAY_W       = 12;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 1'b1;

    typedef enum logic {
        FMT_U8  = 1'b0,
        FMT_S16 = 1'b1
    } t_format;

    // Offset-128 mix, rounded up on a half.
    function automatic logic [SAMPLE_W-1:0] mix8(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
        logic [8:0] sum;
        sum = {1'b0, a[7:0]} + {1'b0, b[7:0]} + 9'd1;
        return {8'd0, sum[8:1]};
    endfunction

    // Signed mix, halved and rounded half away from zero.
    function automatic logic [SAMPLE_W-1:0] mix16(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W+1:0] sum;
        logic signed [SAMPLE_W+1:0] half;
        sum = $signed({{2{a[SAMPLE_W-1]}}, a}) + $signed({{2{b[SAMPLE_W-1]}}, b});
        if (sum >= 0) begin
            half = (sum + 18'sd1) >>> 1;
        end else begin
            half = sum >>> 1;
        end
        return half[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/feedback_comb_echo_unit.sv =====
// Top level of the feedback comb echo unit: pipeline, mixing and configuration.
//
// Usage: input beats carry one sample and a last-of-buffer flag on a
// valid/stall channel; each accepted beat yields exactly one output beat on
// the output valid/stall channel, in order. The echo delay and sample format
// are written through the plain configuration port; the user must do so only
// while the unit is idle, which the block does not enforce. An accepted beat
// reads its echo tap from the history memory, is mixed in the next cycle,
// and moves to the output register when it advances. One beat is taken per
// cycle without output stalls; the single read and single write port of the
// history memory set that rate. A result written back in the same cycle as
// the next beat reads that entry is forwarded around the memory. When the
// receiver stalls, the output register holds its beat and one more beat
// waits in the mix stage; after that the input is stalled. Reset clears the
// pipeline, the write pointer, the buffer position and both registers;
// history entries are only used once written in the current buffer.
`default_nettype none

module feedback_comb_echo_unit #(
    parameter int MAX_DELAY = fce_pkg::MAX_DELAY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fce_pkg::DELAY_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [fce_pkg::SAMPLE_W-1:0]   i_in_sample,
    input  wire logic                           i_last_of_buffer,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [fce_pkg::SAMPLE_W-1:0]   o_out_sample
);

    localparam int AW = $clog2(MAX_DELAY);

    logic [fce_pkg::DELAY_W-1:0]  r_delay;
    fce_pkg::t_format             r_format;

    logic                         r_a_valid;
    logic [fce_pkg::SAMPLE_W-1:0] r_a_x;
    logic                         r_a_mix;
    logic [AW-1:0]                r_a_wa;
    logic                         r_a_fwd;
    logic [fce_pkg::SAMPLE_W-1:0] r_a_fwd_data;

    logic                         r_o_valid;
    logic [fce_pkg::SAMPLE_W-1:0] r_o_sample;

    logic                         accept;
    logic                         adv;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         mix;
    logic [fce_pkg::SAMPLE_W-1:0] rd_data;
    logic [fce_pkg::SAMPLE_W-1:0] past;
    logic [fce_pkg::SAMPLE_W-1:0] x_in;
    logic [fce_pkg::SAMPLE_W-1:0] y;

    always_comb begin
        adv        = r_a_valid && (!r_o_valid || !i_out_stall);
        o_in_stall = r_a_valid && !adv;
        accept     = i_in_valid && !o_in_stall;
        x_in       = (r_format == fce_pkg::FMT_U8) ? {8'd0, i_in_sample[7:0]} : i_in_sample;
        past       = r_a_fwd ? r_a_fwd_data : rd_data;
        if (!r_a_mix) begin
            y = r_a_x;
        end else if (r_format == fce_pkg::FMT_U8) begin
            y = fce_pkg::mix8(r_a_x, past);
        end else begin
            y = fce_pkg::mix16(r_a_x, past);
        end
        o_out_valid  = r_o_valid;
        o_out_sample = r_o_sample;
    end

    fce_addr_gen #(
        .MAX_DELAY (MAX_DELAY),
        .AW        (AW)
    ) u_addr_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_last    (i_last_of_buffer),
        .i_delay   (r_delay),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_mix     (mix)
    );

    fce_hist_mem #(
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (adv),
        .i_wr_addr (r_a_wa),
        .i_wr_data (y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_format <= fce_pkg::FMT_U8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fce_pkg::CFG_ECHO_DELAY: begin
                    r_delay <= i_cfg_data;
                end
                fce_pkg::CFG_SAMPLE_FORMAT: begin
                    r_format <= fce_pkg::t_format'(i_cfg_data[0]);
                end
                default: begin
                    r_delay <= r_delay;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (adv) begin
                r_a_valid <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x        <= x_in;
            r_a_mix      <= mix;
            r_a_wa       <= wr_addr;
            r_a_fwd      <= adv && (r_a_wa == rd_addr);
            r_a_fwd_data <= y;
        end
        if (adv) begin
            r_o_sample <= y;
        end
    end

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !adv |=> r_a_valid && $stable(r_a_x) && $stable(r_a_wa))
        else $error("Mix stage lost or changed a waiting beat.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_out_stall |=> r_o_valid && $stable(r_o_sample))
        else $error("Output register changed under a stall.");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!r_a_valid || !r_o_valid || !i_out_stall))
        else $error("Input taken with no room in the pipeline.");

    a_wr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid && r_a_wa == $past(wr_addr))
        else $error("Accepted beat carries the wrong write address.");

endmodule

`default_nettype wire

// ===== design/fce_hist_mem.sv =====
// History memory of past output samples with one registered read port.
`default_nettype none

module fce_hist_mem #(
    parameter int DEPTH = fce_pkg::MAX_DELAY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [fce_pkg::SAMPLE_W-1:0]  o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [fce_pkg::SAMPLE_W-1:0]  i_wr_data
);

    logic [fce_pkg::SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/fce_addr_gen.sv =====
// Write pointer, buffer position counter and echo tap address generation.
`default_nettype none

module fce_addr_gen #(
    parameter int MAX_DELAY = fce_pkg::MAX_DELAY_DEF,
    parameter int AW        = $clog2(MAX_DELAY)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_last,
    input  wire logic [fce_pkg::DELAY_W-1:0]  i_delay,
    output logic      [AW-1:0]                o_rd_addr,
    output logic      [AW-1:0]                o_wr_addr,
    output logic                              o_mix
);

    localparam int SW = $clog2(MAX_DELAY + 1);
    localparam int XW = (SW > fce_pkg::DELAY_W) ? SW : fce_pkg::DELAY_W;

    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [SW-1:0] r_seen;
    logic [SW-1:0] n_seen;
    logic [XW-1:0] delay_x;
    logic [XW-1:0] d_x;
    logic [AW-1:0] d_a;
    logic [AW:0]   wrap_addr;

    always_comb begin
        delay_x   = XW'(i_delay);
        d_x       = (delay_x >= XW'(MAX_DELAY)) ? XW'(MAX_DELAY - 1) : delay_x;
        d_a       = d_x[AW-1:0];
        wrap_addr = {1'b0, r_wp} + (AW+1)'(MAX_DELAY) - {1'b0, d_a};
        o_rd_addr = (r_wp >= d_a) ? (r_wp - d_a) : wrap_addr[AW-1:0];
        o_wr_addr = r_wp;
        o_mix     = (d_x != '0) && (XW'(r_seen) >= d_x);
    end

    always_comb begin
        n_wp   = r_wp;
        n_seen = r_seen;
        if (i_accept) begin
            n_wp = (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + 1'b1;
            if (i_last) begin
                n_seen = '0;
            end else if (r_seen < SW'(MAX_DELAY)) begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_seen <= '0;
        end else begin
            r_wp   <= n_wp;
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire
